// ----- rtl/core/tcw_pkg.sv -----
// shared types, constants and command codes of the text console writer
package tcw_pkg;

   localparam int COLUMNS_DEFAULT = 80;
   localparam int ROWS_DEFAULT    = 25;

   localparam int CHAR_WIDTH = 8;
   localparam int ATTR_WIDTH = 8;
   localparam int CELL_WIDTH = CHAR_WIDTH + ATTR_WIDTH;
   localparam int POS_WIDTH  = 11;

   localparam logic [CHAR_WIDTH-1:0] BLANK_CHAR        = 8'h20;
   localparam logic [CHAR_WIDTH-1:0] NEWLINE_CHAR      = 8'h0A;
   localparam logic [ATTR_WIDTH-1:0] RESET_BLANK_ATTR  = 8'h0F;

   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;
   localparam logic CSR_IDX_BLANK_ATTR = 1'b0;

   typedef enum logic [1:0] {
      CMD_PUT   = 2'd0,
      CMD_CLEAR = 2'd1,
      CMD_READ  = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   typedef struct packed {
      logic [1:0]            cmd;
      logic [CHAR_WIDTH-1:0] char_code;
      logic [ATTR_WIDTH-1:0] attribute;
      logic [POS_WIDTH-1:0]  cell_address;
   } tcw_req_type;

   typedef struct packed {
      logic [POS_WIDTH-1:0]  cursor_position;
      logic [CHAR_WIDTH-1:0] cell_char;
      logic [ATTR_WIDTH-1:0] cell_attribute;
   } tcw_rsp_type;

endpackage

// ----- rtl/core/tcw_ram.sv -----
// generic simple dual-port ram with one write port and a registered read port
module tcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/tcw_ctrl.sv -----
// command sequencer: cursor, cell writes, read-back, scroll, clear and reset fill
module tcw_ctrl
   import tcw_pkg::*;
#(
   parameter int COLUMNS = COLUMNS_DEFAULT,
   parameter int ROWS    = ROWS_DEFAULT,
   localparam int CellCount = COLUMNS * ROWS,
   localparam int AddrWidth = $clog2(CellCount)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  tcw_req_type           req_item,
   input  logic [ATTR_WIDTH-1:0] blank_attr,
   output logic                  rsp_strobe,
   output tcw_rsp_type           rsp_item,
   output logic                  ram_wr_en,
   output logic [AddrWidth-1:0]  ram_wr_addr,
   output logic [CELL_WIDTH-1:0] ram_wr_data,
   output logic                  ram_rd_en,
   output logic [AddrWidth-1:0]  ram_rd_addr,
   input  logic [CELL_WIDTH-1:0] ram_rd_data
);

   localparam int RowWidth     = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int ColWidth     = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
   localparam int ScrollCount  = CellCount - COLUMNS;
   localparam int LastRowBase  = (ROWS - 1) * COLUMNS;
   localparam int unsigned CellLimit = CellCount;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_READ,
      ST_SCROLL,
      ST_BLANK,
      ST_CLEAR
   } state_type;

   state_type             state_ff, state_in;
   logic [AddrWidth-1:0]  cnt_ff, cnt_in;
   logic [RowWidth-1:0]   row_ff, row_in;
   logic [ColWidth-1:0]   col_ff, col_in;
   logic [AddrWidth-1:0]  pos_ff, pos_in;
   logic                  rd_ok_ff, rd_ok_in;
   logic                  rsp_strobe_ff, rsp_strobe_in;
   tcw_rsp_type           rsp_ff, rsp_in;

   logic                  accept;
   logic                  is_newline;
   logic                  wrap;
   logic [AddrWidth:0]    newline_pos;
   logic [CELL_WIDTH-1:0] blank_cell;
   logic                  last_cnt;

   assign accept      = start && (state_ff == ST_IDLE);
   assign is_newline  = (req_item.char_code == NEWLINE_CHAR);
   assign wrap        = is_newline || (col_ff == ColWidth'(COLUMNS - 1));
   assign newline_pos = (AddrWidth+1)'(pos_ff) - (AddrWidth+1)'(col_ff)
                        + (AddrWidth+1)'(COLUMNS);
   assign blank_cell  = {blank_attr, BLANK_CHAR};
   assign last_cnt    = (cnt_ff == AddrWidth'(CellCount - 1));

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      pos_in        = pos_ff;
      rd_ok_in      = rd_ok_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = pos_ff;
      ram_wr_data   = {req_item.attribute, req_item.char_code};
      ram_rd_en     = 1'b0;
      ram_rd_addr   = AddrWidth'(req_item.cell_address);

      unique case (state_ff)
         ST_INIT: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = cnt_ff;
            ram_wr_data = {RESET_BLANK_ATTR, BLANK_CHAR};
            cnt_in      = cnt_ff + 1'b1;
            if (last_cnt) begin
               cnt_in   = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               rsp_in.cell_char      = '0;
               rsp_in.cell_attribute = '0;
               case (req_item.cmd)
                  CMD_PUT: begin
                     ram_wr_en = !is_newline;
                     if (wrap) begin
                        col_in = '0;
                        if (row_ff == RowWidth'(ROWS - 1)) begin
                           pos_in   = AddrWidth'(LastRowBase);
                           cnt_in   = '0;
                           state_in = ST_SCROLL;
                        end else begin
                           row_in        = row_ff + 1'b1;
                           pos_in        = is_newline ? AddrWidth'(newline_pos)
                                                      : pos_ff + 1'b1;
                           rsp_strobe_in = 1'b1;
                        end
                     end else begin
                        col_in        = col_ff + 1'b1;
                        pos_in        = pos_ff + 1'b1;
                        rsp_strobe_in = 1'b1;
                     end
                  end
                  CMD_CLEAR: begin
                     row_in   = '0;
                     col_in   = '0;
                     pos_in   = '0;
                     cnt_in   = '0;
                     state_in = ST_CLEAR;
                  end
                  CMD_READ: begin
                     ram_rd_en = 1'b1;
                     rd_ok_in  = (32'(req_item.cell_address) < CellLimit);
                     state_in  = ST_READ;
                  end
                  default: begin
                     rsp_strobe_in = 1'b1;
                  end
               endcase
               rsp_in.cursor_position = POS_WIDTH'(pos_in);
            end
         end
         ST_READ: begin
            rsp_strobe_in          = 1'b1;
            rsp_in.cursor_position = POS_WIDTH'(pos_ff);
            rsp_in.cell_char       = rd_ok_ff ? ram_rd_data[CHAR_WIDTH-1:0] : '0;
            rsp_in.cell_attribute  = rd_ok_ff ? ram_rd_data[CELL_WIDTH-1:CHAR_WIDTH]
                                              : '0;
            state_in               = ST_IDLE;
         end
         ST_SCROLL: begin
            // read one row below, write it back in the next cycle
            ram_rd_en   = (cnt_ff != AddrWidth'(ScrollCount));
            ram_rd_addr = cnt_ff + AddrWidth'(COLUMNS);
            ram_wr_en   = (cnt_ff != '0);
            ram_wr_addr = cnt_ff - 1'b1;
            ram_wr_data = ram_rd_data;
            if (cnt_ff == AddrWidth'(ScrollCount)) begin
               state_in = ST_BLANK;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_BLANK, ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = cnt_ff;
            ram_wr_data = blank_cell;
            cnt_in      = cnt_ff + 1'b1;
            if (last_cnt) begin
               cnt_in                 = '0;
               rsp_strobe_in          = 1'b1;
               rsp_in.cursor_position = POS_WIDTH'(pos_ff);
               rsp_in.cell_char       = '0;
               rsp_in.cell_attribute  = '0;
               state_in               = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_INIT;
         cnt_ff        <= '0;
         row_ff        <= '0;
         col_ff        <= '0;
         pos_ff        <= '0;
         rd_ok_ff      <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         row_ff        <= row_in;
         col_ff        <= col_in;
         pos_ff        <= pos_in;
         rd_ok_ff      <= rd_ok_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      rsp_ff <= rsp_in;
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

endmodule

// ----- rtl/core/text_console_writer.sv -----
// top level of the text console writer: register port, sequencer and cell buffer
//
//  channel  | ports                                   | transfer
//  ---------+-----------------------------------------+------------------------------
//  command  | start, busy, req_item                   | start high while busy low
//  result   | rsp_strobe, rsp_item                    | one cycle while rsp_strobe high
//  register | psel, penable, pwrite, paddr, pwdata,   | psel, penable, pwrite, pready
//           | prdata, pready                          | all high
//
//  put that does not scroll: result in the next cycle, next command taken in the next cycle
//  read: through the registered read port of the cell buffer, then the registered result
//  clear: every cell is filled with a blank, then the result; put that scrolls: rows move
//  up one, the last row is blanked, then the result; after reset the buffer is filled with
//  blanks while busy is high; the result channel cannot stall; results are never held back
module text_console_writer
   import tcw_pkg::*;
#(
   parameter int COLUMNS = COLUMNS_DEFAULT,
   parameter int ROWS    = ROWS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  tcw_req_type               req_item,
   output logic                      rsp_strobe,
   output tcw_rsp_type               rsp_item,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [CSR_DATA_WIDTH-1:0] pwdata,
   output logic [CSR_DATA_WIDTH-1:0] prdata,
   output logic                      pready
);

   localparam int CellCount = COLUMNS * ROWS;
   localparam int AddrWidth = $clog2(CellCount);

   logic [ATTR_WIDTH-1:0] blank_attr_ff, blank_attr_in;
   logic                  csr_write;
   logic                  csr_hit;

   logic                  ram_wr_en;
   logic [AddrWidth-1:0]  ram_wr_addr;
   logic [CELL_WIDTH-1:0] ram_wr_data;
   logic                  ram_rd_en;
   logic [AddrWidth-1:0]  ram_rd_addr;
   logic [CELL_WIDTH-1:0] ram_rd_data;

   assign pready    = 1'b1;
   assign csr_hit   = (paddr[CSR_ADDR_WIDTH-1] == CSR_IDX_BLANK_ATTR);
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      blank_attr_in = blank_attr_ff;
      if (csr_write && csr_hit) begin
         blank_attr_in = pwdata[ATTR_WIDTH-1:0];
      end
      prdata = '0;
      if (csr_hit) begin
         prdata = CSR_DATA_WIDTH'(blank_attr_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         blank_attr_ff <= RESET_BLANK_ATTR;
      end else begin
         blank_attr_ff <= blank_attr_in;
      end
   end

   tcw_ctrl #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_item    (req_item),
      .blank_attr  (blank_attr_ff),
      .rsp_strobe  (rsp_strobe),
      .rsp_item    (rsp_item),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data)
   );

   tcw_ram #(
      .WIDTH (CELL_WIDTH),
      .DEPTH (CellCount)
   ) u_cells (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

`ifndef SYNTHESIS
   a_reset_fill: assert property (@(posedge clock) reset |=> busy)
      else $error("buffer fill not running after reset");

   a_read_latency: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_item.cmd == CMD_READ |-> ##2 rsp_strobe)
      else $error("read result not delivered two cycles after transfer");

   a_clear_walks: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_item.cmd == CMD_CLEAR |=> busy && !rsp_strobe)
      else $error("clear did not start a buffer walk");

   a_cell_only_on_read: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_item.cell_char != '0 || rsp_item.cell_attribute != '0)
      |-> $past(busy))
      else $error("cell data on a result that was not a read");
`endif

endmodule
